### hdl/csa_pkg.sv
package csa_pkg;

  localparam int ENCODER_BITS_DEF  = 12;
  localparam int POSITION_BITS_DEF = 32;

  localparam int SUM_BITS  = 48;
  localparam int PROD_BITS = 62;
  localparam int CMD_BITS  = 63;
  localparam int DIV_BITS  = 20;
  localparam int PER_BITS  = 13;
  localparam int TOL_BITS  = 12;
  localparam int RATE_BITS = 20;

  localparam logic [DIV_BITS-1:0] US_PER_S = DIV_BITS'(1000000);
  localparam logic [60:0] PROD_LIM = 61'(1) << 60;

  localparam logic [31:0]          KP_RESET       = 32'd2560000;
  localparam logic [31:0]          KI_RESET       = 32'd0;
  localparam logic [31:0]          KD_RESET       = 32'd25600000;
  localparam logic [TOL_BITS-1:0]  TOL_RESET      = TOL_BITS'(11);
  localparam logic [PER_BITS-1:0]  MIN_PER_RESET  = PER_BITS'(25);
  localparam logic [PER_BITS-1:0]  MAX_PER_RESET  = PER_BITS'(5000);
  localparam logic [PER_BITS-1:0]  HOME_PER_RESET = PER_BITS'(1000);
  localparam logic [RATE_BITS-1:0] RATE_RESET     = RATE_BITS'(40000);

  typedef enum logic [2:0] {
    ACT_SAMPLE  = 3'd0,
    ACT_TARGET  = 3'd1,
    ACT_ENABLE  = 3'd2,
    ACT_DISABLE = 3'd3,
    ACT_HOME    = 3'd4,
    ACT_RESET   = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    REG_KP       = 3'd0,
    REG_KI       = 3'd1,
    REG_KD       = 3'd2,
    REG_TOL      = 3'd3,
    REG_MIN_PER  = 3'd4,
    REG_MAX_PER  = 3'd5,
    REG_HOME_PER = 3'd6,
    REG_MAX_RATE = 3'd7
  } cfg_reg_t;

endpackage

### hdl/csa_if.sv
interface csa_item_if #(
  parameter int ENCODER_BITS = csa_pkg::ENCODER_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [2:0]              action;
  logic                    sample_valid;
  logic [ENCODER_BITS-1:0] angle_raw;
  logic                    control_tick;
  logic                    limit_hit;
  logic [31:0]             now_us;
  logic signed [31:0]      target_value;

  modport source (output valid, action, sample_valid, angle_raw, control_tick, limit_hit,
                  now_us, target_value, input ready);
  modport sink (input valid, action, sample_valid, angle_raw, control_tick, limit_hit,
                now_us, target_value, output ready);
endinterface

interface csa_result_if;
  logic                          valid;
  logic                          ready;
  logic                          step_pulse;
  logic                          direction;
  logic [csa_pkg::PER_BITS-1:0]  step_period;
  logic signed [31:0]            position_counts;
  logic                          homing_active;
  logic                          loop_enabled;

  modport source (output valid, step_pulse, direction, step_period, position_counts,
                  homing_active, loop_enabled, input ready);
  modport sink (input valid, step_pulse, direction, step_period, position_counts,
                homing_active, loop_enabled, output ready);
endinterface

interface csa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/closed_loop_stepper_axis.sv
// Timing: a command, an invalid sample or a sample without control tick
// takes the short path through S_STEP or S_RESULT; a control tick that runs
// PID goes through the shared gain multiplier (16 bits a cycle) for P, I and D,
// then through the divider unless the rate is zero.
// Throughput: one transaction at a time; ready is high only when idle.
// Reset (rst, synchronous, active high) clears the axis, restores registers.
module closed_loop_stepper_axis #(
  parameter int ENCODER_BITS  = csa_pkg::ENCODER_BITS_DEF,
  parameter int POSITION_BITS = csa_pkg::POSITION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  csa_item_if.sink  item,
  csa_result_if.source result,
  csa_cfg_if.sink   cfg
);
  localparam int E    = ENCODER_BITS;
  localparam int P    = POSITION_BITS;
  localparam int TW   = P - E;
  localparam int EW   = ((P > 32) ? P : 32) + 1;   // error width
  localparam int DW   = EW + 1;                     // derivative width
  localparam int SW   = csa_pkg::SUM_BITS;
  localparam int SXW  = SW + 2;
  localparam int VW   = (DW > SW) ? DW : SW;        // multiplier operand width
  localparam int PB   = csa_pkg::PER_BITS;
  localparam int CB   = csa_pkg::CMD_BITS;
  localparam int RB   = csa_pkg::RATE_BITS;
  localparam logic [E-1:0] QUARTER = E'(1) << (E - 2);
  localparam logic [E-1:0] THREE_Q = E'(3) << (E - 2);
  localparam logic signed [SXW-1:0] SUM_LIM = SXW'((64'(1) << 47) - 64'(1));

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_MUL_START, S_MUL_WAIT, S_RATE, S_DIV,
    S_DIV_WAIT, S_PERIOD, S_STEP, S_RESULT
  } state_t;

  typedef enum logic [1:0] {OP_P, OP_I, OP_D} op_t;

  // configuration registers
  logic [31:0]   kp_gain, ki_gain, kd_gain;
  logic [csa_pkg::TOL_BITS-1:0] tolerance_counts;
  logic [PB-1:0] period_floor, period_ceiling, homing_period_us;
  logic [RB-1:0] max_rate_sps;

  // axis state
  logic [E-1:0]          last_angle;
  logic [TW-1:0]         turn_count;
  logic signed [31:0]    target_position;
  logic signed [SW-1:0]  error_sum;
  logic signed [EW-1:0]  previous_error;
  logic                  enabled_flag, homing_flag, direction_flag;
  logic [PB-1:0]         period_register;
  logic [31:0]           next_step_time;

  // sequencer working registers
  state_t                state;
  op_t                   op;
  logic [31:0]           now_q;
  logic signed [EW-1:0]  err_q;
  logic signed [DW-1:0]  deriv_q;
  logic signed [CB-1:0]  cmd;
  logic [RB-1:0]         rate_q;
  logic                  pulse_q;
  logic                  res_valid;

  // combinational helpers
  logic [E-1:0]          ang;
  logic                  wrap_up, wrap_down;
  logic [P-1:0]          pos_bits;
  logic signed [EW-1:0]  err;
  logic signed [SXW-1:0] sum_raw;
  logic signed [SW-1:0]  sum_sat;
  logic signed [DW-1:0]  deriv;
  logic [CB-1:0]         cmd_mag;
  logic [CB-17:0]        rate_full;
  logic [EW-1:0]         aerr;
  logic [csa_pkg::DIV_BITS-1:0] quot;
  logic [PB-1:0]         per_clamp;
  logic [PB-1:0]         per_final;
  logic                  in_tol;
  logic [31:0]           since;

  // shared units
  logic                              mul_start, mul_done;
  logic [31:0]                       mul_gain;
  logic signed [VW-1:0]              mul_value;
  logic signed [csa_pkg::PROD_BITS-1:0] mul_product;
  logic                              div_start, div_done;

  assign ang       = item.angle_raw;
  assign wrap_up   = (last_angle > THREE_Q) && (ang < QUARTER);
  assign wrap_down = (last_angle < QUARTER) && (ang > THREE_Q);
  assign pos_bits  = {turn_count, last_angle};

  // error, saturating integrator and derivative
  assign err     = EW'($signed(target_position)) - EW'($signed(pos_bits));
  assign sum_raw = SXW'(error_sum) + SXW'(err);
  assign sum_sat = (sum_raw > SUM_LIM) ? SW'(SUM_LIM) :
                   (sum_raw < -SUM_LIM) ? SW'(-SUM_LIM) : SW'(sum_raw);
  assign deriv   = DW'(err) - DW'(previous_error);

  // command magnitude to rate
  assign cmd_mag   = cmd[CB-1] ? CB'(-cmd) : CB'(cmd);
  assign rate_full = cmd_mag[CB-1:16];

  // period from quotient, then tolerance, enable and zero-rate overrides
  assign aerr      = err_q[EW-1] ? EW'(-err_q) : EW'(err_q);
  assign in_tol    = aerr <= EW'(tolerance_counts);
  assign per_clamp = (quot < csa_pkg::DIV_BITS'(period_floor)) ? period_floor :
                     (quot > csa_pkg::DIV_BITS'(period_ceiling)) ? period_ceiling :
                     PB'(quot);
  assign per_final = (in_tol || !enabled_flag || rate_q == '0) ? period_ceiling : per_clamp;
  assign since     = now_q - next_step_time;

  always_comb begin
    unique case (op)
      OP_P: begin
        mul_gain  = kp_gain;
        mul_value = VW'(err_q);
      end
      OP_I: begin
        mul_gain  = ki_gain;
        mul_value = VW'(error_sum);
      end
      OP_D: begin
        mul_gain  = kd_gain;
        mul_value = VW'(deriv_q);
      end
      default: begin
        mul_gain  = '0;
        mul_value = '0;
      end
    endcase
  end

  assign mul_start = (state == S_MUL_START);
  assign div_start = (state == S_DIV) && (rate_q != '0);

  csa_gain_mul #(.VW(VW)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .gain    (mul_gain),
    .value   (mul_value),
    .done    (mul_done),
    .product (mul_product)
  );

  csa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (rate_q),
    .done     (div_done),
    .quotient (quot)
  );

  // configuration writes land in any cycle; the sender keeps them to idle time
  assign cfg.ready  = 1'b1;
  assign item.ready = (state == S_IDLE);
  assign result.valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain          <= csa_pkg::KP_RESET;
      ki_gain          <= csa_pkg::KI_RESET;
      kd_gain          <= csa_pkg::KD_RESET;
      tolerance_counts <= csa_pkg::TOL_RESET;
      period_floor     <= csa_pkg::MIN_PER_RESET;
      period_ceiling   <= csa_pkg::MAX_PER_RESET;
      homing_period_us <= csa_pkg::HOME_PER_RESET;
      max_rate_sps     <= csa_pkg::RATE_RESET;
    end else if (cfg.valid) begin
      unique case (csa_pkg::cfg_reg_t'(cfg.index))
        csa_pkg::REG_KP:       kp_gain          <= cfg.data;
        csa_pkg::REG_KI:       ki_gain          <= cfg.data;
        csa_pkg::REG_KD:       kd_gain          <= cfg.data;
        csa_pkg::REG_TOL:      tolerance_counts <= cfg.data[csa_pkg::TOL_BITS-1:0];
        csa_pkg::REG_MIN_PER:  period_floor     <= cfg.data[PB-1:0];
        csa_pkg::REG_MAX_PER:  period_ceiling   <= cfg.data[PB-1:0];
        csa_pkg::REG_HOME_PER: homing_period_us <= cfg.data[PB-1:0];
        csa_pkg::REG_MAX_RATE: max_rate_sps     <= cfg.data[RB-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      op              <= OP_P;
      res_valid       <= 1'b0;
      pulse_q         <= 1'b0;
      last_angle      <= '0;
      turn_count      <= '0;
      target_position <= '0;
      error_sum       <= '0;
      previous_error  <= '0;
      enabled_flag    <= 1'b1;
      homing_flag     <= 1'b0;
      direction_flag  <= 1'b0;
      period_register <= csa_pkg::MAX_PER_RESET;
      next_step_time  <= '0;
    end else begin
      // drop the result once the sink takes it
      if (res_valid && result.ready) res_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            pulse_q <= 1'b0;
            state   <= S_RESULT;
            unique case (csa_pkg::action_t'(item.action))
              csa_pkg::ACT_SAMPLE: begin
                if (item.sample_valid) begin
                  // unwrap turns on the quarter-turn crossings
                  if (wrap_up) turn_count <= turn_count + 1'b1;
                  else if (wrap_down) turn_count <= turn_count - 1'b1;
                  last_angle <= ang;
                  now_q      <= item.now_us;
                  state      <= S_STEP;
                  if (item.control_tick) begin
                    if (homing_flag) begin
                      if (item.limit_hit) begin
                        // home found: zero the axis, hand over to the loop
                        homing_flag     <= 1'b0;
                        enabled_flag    <= 1'b1;
                        turn_count      <= '0;
                        target_position <= '0;
                        error_sum       <= '0;
                        previous_error  <= '0;
                      end else begin
                        direction_flag  <= 1'b1;
                        period_register <= homing_period_us;
                      end
                    end else begin
                      state <= S_ERR;
                    end
                  end
                end
              end
              csa_pkg::ACT_TARGET:  target_position <= item.target_value;
              csa_pkg::ACT_ENABLE:  enabled_flag <= 1'b1;
              csa_pkg::ACT_DISABLE: enabled_flag <= 1'b0;
              csa_pkg::ACT_HOME: begin
                homing_flag  <= 1'b1;
                enabled_flag <= 1'b0;
              end
              csa_pkg::ACT_RESET: begin
                last_angle      <= '0;
                turn_count      <= '0;
                target_position <= '0;
                error_sum       <= '0;
                previous_error  <= '0;
                homing_flag     <= 1'b0;
                direction_flag  <= 1'b0;
                next_step_time  <= '0;
                period_register <= period_ceiling;
                enabled_flag    <= 1'b0;
              end
              default: ;
            endcase
          end
        end

        S_ERR: begin
          err_q          <= err;
          deriv_q        <= deriv;
          error_sum      <= sum_sat;
          previous_error <= err;
          cmd            <= '0;
          op             <= OP_P;
          state          <= S_MUL_START;
        end

        S_MUL_START: state <= S_MUL_WAIT;

        S_MUL_WAIT: begin
          if (mul_done) begin
            // accumulate P, then I, then D through the one multiplier
            cmd <= cmd + CB'(mul_product);
            unique case (op)
              OP_P: begin
                op    <= OP_I;
                state <= S_MUL_START;
              end
              OP_I: begin
                op    <= OP_D;
                state <= S_MUL_START;
              end
              default: state <= S_RATE;
            endcase
          end
        end

        S_RATE: begin
          direction_flag <= !cmd[CB-1] && (cmd != '0);
          rate_q <= (rate_full > (CB-16)'(max_rate_sps)) ? max_rate_sps : RB'(rate_full);
          state  <= S_DIV;
        end

        S_DIV: state <= (rate_q != '0) ? S_DIV_WAIT : S_PERIOD;

        S_DIV_WAIT: if (div_done) state <= S_PERIOD;

        S_PERIOD: begin
          period_register <= per_final;
          if (in_tol) error_sum <= '0;
          state <= S_STEP;
        end

        S_STEP: begin
          // issue a step when due, measured against the wrapping microsecond time
          if ((enabled_flag || homing_flag) && (period_register < period_ceiling) &&
              !since[31]) begin
            pulse_q        <= 1'b1;
            next_step_time <= next_step_time + 32'(period_register);
          end
          state <= S_RESULT;
        end

        S_RESULT: begin
          // hold until the output register is free
          if (!res_valid || result.ready) begin
            res_valid              <= 1'b1;
            result.step_pulse      <= pulse_q;
            result.direction       <= direction_flag;
            result.step_period     <= period_register;
            result.position_counts <= 32'(pos_bits);
            result.homing_active   <= homing_flag;
            result.loop_enabled    <= enabled_flag;
            state                  <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/csa_gain_mul.sv
module csa_gain_mul #(
  parameter int VW = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [31:0]                          gain,
  input  logic signed [VW-1:0]                 value,
  output logic                                 done,
  output logic signed [csa_pkg::PROD_BITS-1:0] product
);
  localparam int NCH  = (VW + 15) / 16;
  localparam int CW   = NCH * 16;
  localparam int AW   = CW + 32;
  localparam int CNTW = $clog2(NCH + 1);

  logic            busy;
  logic            fin;
  logic [CNTW-1:0] cnt;
  logic [CW-1:0]   mag;
  logic [AW-1:0]   acc;
  logic [31:0]     g;
  logic            neg;
  logic [VW-1:0]   mag_in;
  logic [47:0]     pp;
  logic [60:0]     sat;

  assign mag_in = value[VW-1] ? VW'(-value) : VW'(value);
  assign pp     = {16'b0, g} * {32'b0, mag[CW-1 -: 16]};
  assign sat    = (acc > AW'(csa_pkg::PROD_LIM)) ? csa_pkg::PROD_LIM : acc[60:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        g    <= gain;
        neg  <= value[VW-1];
        mag  <= CW'(mag_in);
        acc  <= '0;
        cnt  <= CNTW'(NCH);
        busy <= 1'b1;
      end else if (busy) begin
        // MSB chunk first: shift the running sum up and add the new partial
        acc <= (acc << 16) + AW'(pp);
        mag <= mag << 16;
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        done    <= 1'b1;
        product <= neg ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
      end
    end
  end
endmodule

### hdl/csa_div.sv
module csa_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [csa_pkg::DIV_BITS-1:0] divisor,
  output logic                         done,
  output logic [csa_pkg::DIV_BITS-1:0] quotient
);
  localparam int NW   = csa_pkg::DIV_BITS;
  localparam int CNTW = $clog2(NW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   d;
  logic [NW-1:0]   rem;
  logic [NW:0]     rem_sh;
  logic            fits;

  assign rem_sh = {rem, quotient[NW-1]};
  assign fits   = rem_sh >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        d        <= divisor;
        rem      <= '0;
        quotient <= csa_pkg::US_PER_S;
        cnt      <= CNTW'(NW);
        busy     <= 1'b1;
      end else if (busy) begin
        // restoring division, one quotient bit per cycle
        rem      <= fits ? NW'(rem_sh - {1'b0, d}) : NW'(rem_sh);
        quotient <= {quotient[NW-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
